/* hw/rtl/chd_pkg.sv */
// Shared types, character codes and byte classifiers for the chunked body decoder.
// No dependencies; imported by chd_step and the top level.
`default_nettype none

package chd_pkg;

  // Size-line parse and payload phases
  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_SIGN   = 3'd1,
    PH_ZERO   = 3'd2,
    PH_PREFIX = 3'd3,
    PH_DIGITS = 3'd4,
    PH_SKIP   = 3'd5,
    PH_DATA   = 3'd6,
    PH_DONE   = 3'd7
  } phase_e;

  // Control state carried between the step logic and the state registers
  typedef struct packed {
    phase_e phase;
    logic   saw_cr;
  } ctrl_t;

  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_VT    = 8'h0B;
  localparam logic [7:0] CHR_FF    = 8'h0C;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_X_LO  = 8'h78;
  localparam logic [7:0] CHR_X_UP  = 8'h58;
  localparam int unsigned HEX_RADIX_BITS = 4;  // log2 of radix 16

  // strtol whitespace class
  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == CHR_SPACE) || (c == CHR_TAB) || (c == CHR_LF) ||
               (c == CHR_VT) || (c == CHR_FF) || (c == CHR_CR);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  // Digit value; only meaningful where is_hex holds
  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    hex_digit = v[3:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/chd_step.sv */
// Next-state and result logic for one body byte of the chunked decoder.
// Depends on chd_pkg for phase codes, character codes and classifiers.
`default_nettype none

module chd_step #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  var chd_pkg::ctrl_t        ctrl_q_i,
  input  var logic [SIZE_BITS-1:0]  count_q_i,
  input  var logic [7:0]            byte_i,
  output var chd_pkg::ctrl_t        ctrl_d_o,
  output var logic [SIZE_BITS-1:0]  count_d_o,
  output var logic                  pass_o,
  output var logic                  finished_o
);
  import chd_pkg::*;

  logic                 hex;
  logic [3:0]           dig;
  logic [SIZE_BITS-1:0] base;
  logic [SIZE_BITS-1:0] shifted;
  logic                 end_zero;
  logic [SIZE_BITS-1:0] dec;

  // Accumulate one hex digit, saturating at the all-ones size
  assign hex  = is_hex(byte_i);
  assign dig  = hex_digit(byte_i);
  assign base = (ctrl_q_i.phase == PH_LEAD) ? '0 : count_q_i;
  assign shifted = (|base[SIZE_BITS-1 -: HEX_RADIX_BITS]) ? '1 :
                   {base[SIZE_BITS-HEX_RADIX_BITS-1:0], dig};
  assign end_zero = (count_q_i == '0);
  assign dec      = count_q_i - SIZE_BITS'(1);

  always_comb begin
    ctrl_d_o  = ctrl_q_i;
    count_d_o = count_q_i;
    pass_o    = 1'b0;
    case (ctrl_q_i.phase)
      PH_LEAD: begin
        if (!is_space(byte_i)) begin
          count_d_o = '0;
          if (byte_i == CHR_PLUS) begin
            ctrl_d_o.phase = PH_SIGN;
          end else if (byte_i == CHR_MINUS) begin
            ctrl_d_o.phase = PH_DONE;
          end else if (byte_i == CHR_ZERO) begin
            ctrl_d_o.phase = PH_ZERO;
          end else if (hex) begin
            count_d_o      = shifted;
            ctrl_d_o.phase = PH_DIGITS;
          end else begin
            ctrl_d_o.phase = PH_DONE;
          end
        end
      end
      PH_SIGN: begin
        if (byte_i == CHR_ZERO) begin
          ctrl_d_o.phase = PH_ZERO;
        end else if (hex) begin
          count_d_o      = shifted;
          ctrl_d_o.phase = PH_DIGITS;
        end else begin
          ctrl_d_o.phase = PH_DONE;
        end
      end
      PH_ZERO, PH_DIGITS: begin
        if (ctrl_q_i.phase == PH_ZERO &&
            (byte_i == CHR_X_LO || byte_i == CHR_X_UP)) begin
          ctrl_d_o.phase = PH_PREFIX;
        end else if (hex) begin
          count_d_o      = shifted;
          ctrl_d_o.phase = PH_DIGITS;
        end else if (end_zero) begin
          // zero-size chunk terminates the body
          ctrl_d_o.phase = PH_DONE;
        end else begin
          ctrl_d_o.phase  = PH_SKIP;
          ctrl_d_o.saw_cr = (byte_i == CHR_CR);
        end
      end
      PH_PREFIX: begin
        if (hex) begin
          count_d_o      = shifted;
          ctrl_d_o.phase = PH_DIGITS;
        end else begin
          ctrl_d_o.phase = PH_DONE;
        end
      end
      PH_SKIP: begin
        // drop the rest of the size line up to CR LF
        if (ctrl_q_i.saw_cr && byte_i == CHR_LF) begin
          ctrl_d_o.saw_cr = 1'b0;
          ctrl_d_o.phase  = end_zero ? PH_LEAD : PH_DATA;
        end else begin
          ctrl_d_o.saw_cr = (byte_i == CHR_CR);
        end
      end
      PH_DATA: begin
        if (!end_zero) begin
          pass_o    = 1'b1;
          count_d_o = dec;
        end
        if (end_zero || dec == '0) begin
          ctrl_d_o.phase = PH_LEAD;
        end
      end
      default: begin
        ctrl_d_o.phase = PH_DONE;
      end
    endcase
  end

  assign finished_o = (ctrl_d_o.phase == PH_DONE);

endmodule

`default_nettype wire

/* hw/rtl/http_chunked_body_decoder_unit.sv */
// Top level of the HTTP/1.1 chunked body decoder: input register, decode state
// and result register. Depends on chd_pkg and chd_step.
`default_nettype none

// Decodes a chunked message body one byte per transfer and returns one result
// per input byte: the byte with out_valid set when it is payload, and the
// finished flag once a zero, negative or malformed chunk size has ended the
// body. A byte with frame_end set is decoded normally and then returns the
// decoder to its reset state. Throughput is one byte per clock cycle while
// res_ready is high; a byte passes through the input register, then through the
// decode logic into the result register. The size counter is SIZE_BITS wide and
// saturates at its all-ones value.
module http_chunked_body_decoder_unit #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  var logic       clk_i,
  input  var logic       rst_ni,
  input  var logic       in_valid_i,
  output var logic       in_ready_o,
  input  var logic [7:0] in_byte_i,
  input  var logic       frame_end_i,
  output var logic       res_valid_o,
  input  var logic       res_ready_i,
  output var logic [7:0] out_byte_o,
  output var logic       out_valid_o,
  output var logic       finished_o
);
  import chd_pkg::*;

  logic                 s1_valid_q;
  logic [7:0]           s1_byte_q;
  logic                 s1_fe_q;
  logic                 s1_adv;
  ctrl_t                ctrl_q, ctrl_d;
  logic [SIZE_BITS-1:0] count_q, count_d;
  logic                 pass;
  logic                 fin;
  logic                 res_valid_q;
  logic [7:0]           out_byte_q;
  logic                 out_valid_q;
  logic                 finished_q;

  // Advance the input register into the result register when it is free
  assign s1_adv     = s1_valid_q && (!res_valid_q || res_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  chd_step #(
    .SIZE_BITS(SIZE_BITS)
  ) u_step (
    .ctrl_q_i  (ctrl_q),
    .count_q_i (count_q),
    .byte_i    (s1_byte_q),
    .ctrl_d_o  (ctrl_d),
    .count_d_o (count_d),
    .pass_o    (pass),
    .finished_o(fin)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= in_byte_i;
      s1_fe_q   <= frame_end_i;
    end
  end

  // Decode state: update per byte, return to reset after frame end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q  <= '{phase: PH_LEAD, saw_cr: 1'b0};
      count_q <= '0;
    end else if (s1_adv) begin
      if (s1_fe_q) begin
        ctrl_q  <= '{phase: PH_LEAD, saw_cr: 1'b0};
        count_q <= '0;
      end else begin
        ctrl_q  <= ctrl_d;
        count_q <= count_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (!res_valid_q || res_ready_i) begin
      res_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_byte_q  <= pass ? s1_byte_q : 8'h00;
      out_valid_q <= pass;
      finished_q  <= fin;
    end
  end

  assign res_valid_o = res_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_valid_o = out_valid_q;
  assign finished_o  = finished_q;

endmodule

`default_nettype wire

/* dv/http_chunked_body_decoder_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for http_chunked_body_decoder_unit: feeds chunked bodies and noise
// with random spacing on both channels, decodes each byte in-bench and checks every result.
// Depends on chd_pkg and the decoder RTL.
module http_chunked_body_decoder_unit_tb;
  import chd_pkg::*;

  localparam int unsigned SIZE_W = 32;
  localparam logic [SIZE_W-1:0] CNT_MAX = '1;
  localparam int unsigned N_ITEMS = 1150;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_AT = 300;
  localparam int unsigned HOLD_LEN = 150;
  localparam int unsigned TAIL_WAIT = 8;
  localparam int unsigned DRAIN_AT = 600;
  localparam logic [7:0] CHR_SEMI = 8'h3B;
  localparam logic [7:0] CHR_LOWER_A = 8'h61;
  localparam logic [7:0] CHR_Q = 8'h71;

  typedef struct {
    logic [7:0]  b;
    logic        fe;
    int unsigned gap;
    bit          drain;
  } body_byte_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       finished;
  } dec_res_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic [7:0] in_byte_i = 8'h00;
  logic       frame_end_i = 1'b0;
  logic       res_ready_i = 1'b0;
  logic       in_ready_o;
  logic       res_valid_o;
  logic [7:0] out_byte_o;
  logic       out_valid_o;
  logic       finished_o;

  body_byte_t  body_q[$];
  dec_res_t    decoded_q[$];
  body_byte_t  cur_byte;
  int unsigned n_offered = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned n_cycles = 0;
  int unsigned n_errors = 0;
  int unsigned tx_gap = 0;
  bit          tx_gap_armed = 1'b0;
  int unsigned rx_stall = 0;
  bit          rx_held = 1'b0;
  bit          burst = 1'b0;
  bit          next_drain = 1'b0;

  // Decoder state mirrored in the bench
  phase_e            st_phase = PH_LEAD;
  logic [SIZE_W-1:0] st_count = '0;
  logic              st_saw_cr = 1'b0;

  http_chunked_body_decoder_unit #(
    .SIZE_BITS(SIZE_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .frame_end_i(frame_end_i),
    .res_valid_o(res_valid_o),
    .res_ready_i(res_ready_i),
    .out_byte_o (out_byte_o),
    .out_valid_o(out_valid_o),
    .finished_o (finished_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic chr_is_ws(input logic [7:0] c);
    return (c == CHR_SPACE) || (c == CHR_TAB) || (c == CHR_LF) || (c == CHR_VT) ||
           (c == CHR_FF) || (c == CHR_CR);
  endfunction

  // Hex digit value, -1 for anything else
  function automatic int hex_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h57;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;
    return -1;
  endfunction

  // Shift in one digit, saturating at the all-ones size
  function automatic void shift_digit(input logic [3:0] d);
    if (st_count > (CNT_MAX >> 4)) begin
      st_count = CNT_MAX;
    end else begin
      st_count = {st_count[SIZE_W-5:0], d};
    end
  endfunction

  // Digit run ended: a zero size ends the body, else skip to CR LF
  function automatic void close_number(input logic [7:0] c);
    if (st_count == '0) begin
      st_phase = PH_DONE;
    end else begin
      st_phase = PH_SKIP;
      st_saw_cr = (c == CHR_CR);
    end
  endfunction

  function automatic dec_res_t decode_byte(input logic [7:0] c, input logic fe);
    dec_res_t r;
    logic     pass;
    int       d;
    pass = 1'b0;
    d = hex_of(c);
    case (st_phase)
      PH_LEAD: begin
        if (!chr_is_ws(c)) begin
          st_count = '0;
          if (c == CHR_PLUS) st_phase = PH_SIGN;
          else if (c == CHR_MINUS) st_phase = PH_DONE;
          else if (c == CHR_ZERO) st_phase = PH_ZERO;
          else if (d >= 0) begin
            shift_digit(d[3:0]);
            st_phase = PH_DIGITS;
          end else st_phase = PH_DONE;
        end
      end
      PH_SIGN: begin
        if (c == CHR_ZERO) st_phase = PH_ZERO;
        else if (d >= 0) begin
          shift_digit(d[3:0]);
          st_phase = PH_DIGITS;
        end else st_phase = PH_DONE;
      end
      PH_ZERO: begin
        if (c == CHR_X_LO || c == CHR_X_UP) st_phase = PH_PREFIX;
        else if (d >= 0) begin
          shift_digit(d[3:0]);
          st_phase = PH_DIGITS;
        end else close_number(c);
      end
      PH_PREFIX: begin
        if (d >= 0) begin
          shift_digit(d[3:0]);
          st_phase = PH_DIGITS;
        end else st_phase = PH_DONE;
      end
      PH_DIGITS: begin
        if (d >= 0) shift_digit(d[3:0]);
        else close_number(c);
      end
      PH_SKIP: begin
        if (st_saw_cr && c == CHR_LF) begin
          st_saw_cr = 1'b0;
          st_phase = (st_count == '0) ? PH_LEAD : PH_DATA;
        end else begin
          st_saw_cr = (c == CHR_CR);
        end
      end
      PH_DATA: begin
        if (st_count != '0) begin
          pass = 1'b1;
          st_count = st_count - SIZE_W'(1);
        end
        if (st_count == '0) st_phase = PH_LEAD;
      end
      default: st_phase = PH_DONE;
    endcase
    r.out_byte = pass ? c : 8'h00;
    r.out_valid = pass;
    r.finished = (st_phase == PH_DONE);
    // Frame end returns everything to reset after the byte is decoded
    if (fe) begin
      st_phase = PH_LEAD;
      st_count = '0;
      st_saw_cr = 1'b0;
    end
    return r;
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] hex_chr(input logic [3:0] d);
    if (d < 10) return CHR_ZERO + {4'h0, d};
    return ($urandom_range(0, 1) ? 8'h41 : CHR_LOWER_A) + {4'h0, d} - 8'd10;
  endfunction

  function automatic logic [7:0] rand_ws();
    case ($urandom_range(0, 5))
      0: return CHR_SPACE;
      1: return CHR_TAB;
      2: return CHR_LF;
      3: return CHR_VT;
      4: return CHR_FF;
      default: return CHR_CR;
    endcase
  endfunction

  // A byte that cannot start or continue a size
  function automatic logic [7:0] rand_nonhex();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (hex_of(c) >= 0 || chr_is_ws(c) || c == CHR_PLUS || c == CHR_MINUS)
      c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 12);
    return $urandom_range(13, 48);
  endfunction

  task automatic push_byte(input logic [7:0] b);
    body_byte_t it;
    it.b = b;
    it.fe = 1'b0;
    it.gap = burst ? 0 : gap_len();
    it.drain = next_drain;
    next_drain = 1'b0;
    body_q.push_back(it);
  endtask

  task automatic close_frame();
    body_q[body_q.size()-1].fe = 1'b1;
  endtask

  task automatic put_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic put_crlf();
    push_byte(CHR_CR);
    push_byte(CHR_LF);
  endtask

  task automatic put_data(input int unsigned n);
    repeat (n) push_byte(8'($urandom_range(0, 255)));
  endtask

  // Size line with random whitespace, sign, prefix, leading zeros and extension
  task automatic put_size_line(input logic [SIZE_W-1:0] sz, input bit huge);
    int nd;
    int i;
    int r;
    repeat ($urandom_range(0, 2)) push_byte(rand_ws());
    if ($urandom_range(0, 7) == 0) push_byte(CHR_PLUS);
    if ($urandom_range(0, 3) == 0) begin
      push_byte(CHR_ZERO);
      push_byte($urandom_range(0, 1) ? CHR_X_UP : CHR_X_LO);
    end
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) push_byte(CHR_ZERO);
    if (huge) begin
      push_byte(hex_chr(4'($urandom_range(1, 15))));
      repeat ($urandom_range(8, 11)) push_byte(hex_chr(4'($urandom_range(0, 15))));
    end else begin
      nd = 1;
      while (nd < SIZE_W / 4 && (sz >> (4 * nd)) != 0) nd++;
      for (i = nd - 1; i >= 0; i--) push_byte(hex_chr(sz[4*i +: 4]));
    end
    r = $urandom_range(0, 99);
    if (r >= 70 && r < 85) begin
      push_byte(CHR_SEMI);
      repeat ($urandom_range(1, 5)) push_byte(CHR_LOWER_A + 8'($urandom_range(0, 25)));
    end else if (r >= 85 && r < 95) begin
      push_byte(CHR_SPACE);
      push_byte(CHR_SEMI);
    end else if (r >= 95) begin
      // lone CR inside the extension must not end the line
      push_byte(CHR_SEMI);
      push_byte(CHR_CR);
      push_byte(CHR_Q);
    end
    put_crlf();
  endtask

  // One framed body: a few chunks and one of several endings, or a run of noise
  task automatic gen_message();
    int                r;
    logic [SIZE_W-1:0] sz;
    bit                huge;
    burst = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 39) == 0) next_drain = 1'b1;
    if ($urandom_range(0, 99) < 8) begin
      // noise with stray frame ends
      repeat ($urandom_range(1, 12)) begin
        push_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 7) == 0) close_frame();
      end
    end else begin
      repeat ($urandom_range(0, 3)) begin
        sz = pick_size();
        put_size_line(sz, 1'b0);
        put_data(sz);
        r = $urandom_range(0, 99);
        if (r < 85) begin
          put_crlf();
        end else if (r >= 95) begin
          push_byte(CHR_SPACE);
          push_byte(CHR_TAB);
        end
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
        // last chunk, then a trailer that is dropped
        put_size_line('0, 1'b0);
        put_data($urandom_range(0, 4));
        put_crlf();
      end else if (r < 63) begin
        push_byte(CHR_MINUS);
        push_byte(hex_chr(4'($urandom_range(0, 15))));
        put_crlf();
      end else if (r < 71) begin
        // sign or bare prefix with no digit behind it
        case ($urandom_range(0, 2))
          0: push_byte(CHR_PLUS);
          1: begin
            push_byte(CHR_ZERO);
            push_byte(CHR_X_LO);
          end
          default: ;
        endcase
        push_byte(rand_nonhex());
        put_crlf();
      end else if (r < 81) begin
        // data cut short by the frame end, sometimes after a saturated size
        huge = ($urandom_range(0, 2) == 0);
        sz = pick_size() + SIZE_W'(1);
        put_size_line(sz, huge);
        put_data(huge ? $urandom_range(1, 6) : $urandom_range(0, sz - 1));
      end else if (r < 90) begin
        // size line that never reaches CR LF
        push_byte(hex_chr(4'($urandom_range(1, 15))));
        push_byte(CHR_SEMI);
        if ($urandom_range(0, 1)) push_byte(CHR_CR);
      end else begin
        push_byte(rand_ws());
        if ($urandom_range(0, 1)) push_byte(CHR_PLUS);
        if ($urandom_range(0, 1)) begin
          push_byte(CHR_ZERO);
          push_byte(CHR_X_UP);
        end
      end
    end
    close_frame();
  endtask

  // Drive the input channel; hold the payload until the transfer happens
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && n_accepted != n_offered)) begin
      if (!tx_gap_armed && body_q.size() != 0) begin
        tx_gap = body_q[0].gap;
        tx_gap_armed = 1'b1;
      end
      if (tx_gap != 0) begin
        in_valid_i <= 1'b0;
        tx_gap--;
      end else if (body_q.size() != 0 && (!body_q[0].drain || decoded_q.size() == 0)) begin
        cur_byte = body_q.pop_front();
        in_byte_i <= cur_byte.b;
        frame_end_i <= cur_byte.fe;
        in_valid_i <= 1'b1;
        n_offered++;
        tx_gap_armed = 1'b0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Drive the result ready: random stalls, calm stretches and one long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!rx_held && n_results >= HOLD_AT) begin
        rx_held = 1'b1;
        rx_stall = HOLD_LEN;
      end
      if (rx_stall != 0) begin
        res_ready_i <= 1'b0;
        rx_stall--;
      end else begin
        res_ready_i <= 1'b1;
        if ((n_cycles / 600) % 4 != 3) rx_stall = gap_len();
      end
    end
  end

  // Predict on each input transfer
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      decoded_q.push_back(decode_byte(in_byte_i, frame_end_i));
      n_accepted++;
    end
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk_i) begin
    dec_res_t want;
    if (rst_ni && res_valid_o && res_ready_i) begin
      n_results++;
      if (decoded_q.size() == 0) begin
        $error("result with nothing pending: out_byte %02h out_valid %0b finished %0b",
               out_byte_o, out_valid_o, finished_o);
        n_errors++;
      end else begin
        want = decoded_q.pop_front();
        if (out_byte_o !== want.out_byte) begin
          $error("out_byte mismatch: expected %02h, got %02h", want.out_byte, out_byte_o);
          n_errors++;
        end
        if (out_valid_o !== want.out_valid) begin
          $error("out_valid mismatch: expected %0b, got %0b", want.out_valid, out_valid_o);
          n_errors++;
        end
        if (finished_o !== want.finished) begin
          $error("finished mismatch: expected %0b, got %0b", want.finished, finished_o);
          n_errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("http_chunked_body_decoder_unit_tb failed");
      $finish;
    end
  end

  initial begin
    int unsigned n_dir;
    bit          drain_set;
    drain_set = 1'b0;
    // Directed: leading tab, VT, FF and space, plus sign, upper prefix, extension, extreme data bytes
    push_byte(CHR_TAB);
    push_byte(CHR_VT);
    push_byte(CHR_FF);
    push_byte(CHR_SPACE);
    put_text("+0X2;");
    put_crlf();
    push_byte(8'hFF);
    push_byte(8'h00);
    put_crlf();
    // zero size ends the body
    put_text("0");
    put_crlf();
    close_frame();
    // minus sign ends the body at once
    put_text("-");
    close_frame();
    // bare prefix, then bytes dropped after the end
    put_text("0xgz");
    close_frame();
    // line without digits
    put_text("q");
    close_frame();
    n_dir = body_q.size();
    while (body_q.size() < N_ITEMS + n_dir) begin
      if (!drain_set && body_q.size() >= DRAIN_AT) begin
        next_drain = 1'b1;
        drain_set = 1'b1;
      end
      gen_message();
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for all transfers and results, then a tail wait for strays
    while (body_q.size() != 0 || n_accepted != n_offered) @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("http_chunked_body_decoder_unit_tb passed");
    end else begin
      $display("http_chunked_body_decoder_unit_tb failed");
    end
    $finish;
  end

endmodule
